// File: design/pft_pkg.sv
// Package for the page frame table: sizes, command codes, request/result structs.
// No dependencies.
`default_nettype none
package pft_pkg;
    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 24;
    localparam int IDX_BITS  = $clog2(FRAMES);
    localparam int CNT_BITS  = $clog2(FRAMES + 1);

    localparam logic [2:0] CMD_PIN   = 3'd0;
    localparam logic [2:0] CMD_UNPIN = 3'd1;
    localparam logic [2:0] CMD_DIRTY = 3'd2;
    localparam logic [2:0] CMD_FORCE = 3'd3;
    localparam logic [2:0] CMD_FLUSH = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_PINNED  = 2'd2;

    localparam logic [0:0] REG_STRATEGY = 1'd0;
    localparam logic [0:0] REG_FRAMES   = 1'd1;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [PAGE_BITS-1:0] page_number;
    } req_t;

    typedef struct packed {
        logic [3:0]           frame;
        logic                 hit;
        logic                 load;
        logic                 write_back;
        logic [PAGE_BITS-1:0] written_page;
        logic [1:0]           status;
        logic [31:0]          read_total;
        logic [31:0]          write_total;
        logic [7:0]           pin_count;
        logic                 last;
    } res_t;

    // Per-frame view presented to the scan unit
    typedef struct packed {
        logic                 valid;
        logic                 dirty;
        logic [7:0]           pins;
        logic [PAGE_BITS-1:0] page;
        logic [31:0]          stamp;
    } frm_t;
endpackage
`default_nettype wire

// File: design/pft_top_scan.sv
// One-frame-per-cycle compare unit shared by all scans of the frame table.
// Depends on pft_pkg.
`default_nettype none
module pft_scan
    import pft_pkg::*;
(
    input  var frm_t                 f,
    input  var logic [PAGE_BITS-1:0] page,
    input  var logic [31:0]          best_stamp,
    input  var logic                 have_best,
    output var logic                 match,
    output var logic                 empty,
    output var logic                 free,
    output var logic                 older
);
    assign match = f.valid && (f.page == page);
    assign empty = !f.valid;
    assign free  = (f.pins == 8'd0);
    assign older = free && (!have_best || (f.stamp < best_stamp));
endmodule
`default_nettype wire

// File: design/page_frame_table_fifo_lru_top.sv
// Top level of the page frame table with FIFO/LRU replacement: frame table,
// sequencer and the shared per-frame compare unit. Depends on pft_pkg, pft_scan.
//
// Usage: raise start with a request (cmd, page_number) while busy is low. The
// block raises busy and walks the active frames one per cycle: a hit search,
// then on a pin miss an empty-frame search, then a victim search (FIFO from
// the rotating pointer or least stamp under LRU). Each pass visits up to n
// frames (n = active frames, at most 16). A pin miss with every frame pinned
// walks the hit, empty-frame and victim searches before its pinned result.
// busy drops in the cycle of the last result, so the next request can be
// taken at the edge ending it. Flush all walks the frames once and holds
// each write result back one slot so the final one can carry last; it
// strobes at most one result per cycle, or one empty result when nothing is
// written. Results are shown for one cycle on res with valid; the receiver
// cannot stall. Configuration (cfg_we, cfg_index, cfg_data) must be written
// only while idle; the block itself does not enforce it. Reset clears valid,
// dirty and pin state, counters, the FIFO pointer, sets strategy FIFO and 16
// frames; page and stamp stores need no clearing.
`default_nettype none
module page_frame_table_fifo_lru_top
    import pft_pkg::*;
(
    input  var logic       clk,
    input  var logic       rst_n,
    input  var logic       start,
    output var logic       busy,
    input  var req_t       req,
    output var logic       valid,
    output var res_t       res,
    input  var logic       cfg_we,
    input  var logic [0:0] cfg_index,
    input  var logic [4:0] cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_EMPTY, S_VICT, S_FLUSH, S_TAIL, S_DONE
    } state_t;

    state_t                state_reg;
    logic                  valid_reg;
    res_t                  res_reg;
    res_t                  pend_reg;
    logic [FRAMES-1:0]     fvalid_reg, fdirty_reg;
    logic [7:0]            fpins_reg  [FRAMES];
    logic [PAGE_BITS-1:0]  fpage_reg  [FRAMES];
    logic [31:0]           fstamp_reg [FRAMES];
    logic [31:0]           stamp_reg, rd_reg, wr_reg;
    logic [IDX_BITS-1:0]   fptr_reg, idx_reg, cnt_reg, best_reg;
    logic                  have_reg, any_reg, strat_reg;
    logic [4:0]            nfr_reg;
    req_t                  q_reg;

    logic [CNT_BITS-1:0] n;
    logic [IDX_BITS-1:0] nm1, idx_inc;
    logic                lastf;
    frm_t                cur;
    logic                m_match, m_empty, m_free, m_older;

    always_comb
    begin
        if (nfr_reg == 5'd0)
            n = CNT_BITS'(1);
        else if (32'(nfr_reg) > FRAMES)
            n = CNT_BITS'(FRAMES);
        else
            n = CNT_BITS'(nfr_reg);
        nm1     = IDX_BITS'(n - CNT_BITS'(1));
        idx_inc = (idx_reg == nm1) ? '0 : idx_reg + 1'b1;
        lastf   = (cnt_reg == nm1);
        cur     = '{fvalid_reg[idx_reg], fdirty_reg[idx_reg], fpins_reg[idx_reg],
                    fpage_reg[idx_reg], fstamp_reg[idx_reg]};
    end

    pft_scan u_scan (
        .f(cur), .page(q_reg.page_number), .best_stamp(fstamp_reg[best_reg]),
        .have_best(have_reg), .match(m_match), .empty(m_empty), .free(m_free),
        .older(m_older)
    );

    assign busy  = (state_reg != S_IDLE);
    assign valid = valid_reg;
    assign res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            res_reg    <= '0;
            pend_reg   <= '0;
            q_reg      <= '0;
            fvalid_reg <= '0;
            fdirty_reg <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                fpins_reg[i] <= 8'd0;
            end
            stamp_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
            fptr_reg  <= '0;
            strat_reg <= 1'b0;
            nfr_reg   <= 5'd16;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            best_reg  <= '0;
            have_reg  <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            logic valid_next;
            res_t res_next;
            valid_next = 1'b0;
            res_next   = res_reg;
            if (cfg_we)
            begin
                if (cfg_index == REG_STRATEGY)
                    strat_reg <= cfg_data[0];
                else
                    nfr_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        q_reg   <= req;
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        any_reg <= 1'b0;
                        if (req.cmd <= CMD_FORCE)
                            state_reg <= S_FIND;
                        else if (req.cmd == CMD_FLUSH)
                            state_reg <= S_FLUSH;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_FIND:
                begin
                    if (m_match)
                    begin
                        state_reg  <= S_IDLE;
                        valid_next = 1'b1;
                        res_next   = '0;
                        res_next.frame       = 4'(idx_reg);
                        res_next.hit         = 1'b1;
                        res_next.last        = 1'b1;
                        res_next.read_total  = rd_reg;
                        res_next.write_total = wr_reg;
                        res_next.pin_count   = cur.pins;
                        case (q_reg.cmd)
                            CMD_PIN:
                            begin
                                if (cur.pins != 8'hFF)
                                begin
                                    fpins_reg[idx_reg] <= cur.pins + 8'd1;
                                    res_next.pin_count = cur.pins + 8'd1;
                                end
                                stamp_reg <= stamp_reg + 32'd1;
                                if (strat_reg)
                                    fstamp_reg[idx_reg] <= stamp_reg + 32'd1;
                            end
                            CMD_UNPIN:
                            begin
                                if (cur.pins != 8'd0)
                                begin
                                    fpins_reg[idx_reg] <= cur.pins - 8'd1;
                                    res_next.pin_count = cur.pins - 8'd1;
                                end
                            end
                            CMD_DIRTY:
                                fdirty_reg[idx_reg] <= 1'b1;
                            default:
                            begin
                                fdirty_reg[idx_reg]   <= 1'b0;
                                wr_reg                <= wr_reg + 32'd1;
                                res_next.write_total  = wr_reg + 32'd1;
                                res_next.write_back   = 1'b1;
                                res_next.written_page = cur.page;
                            end
                        endcase
                    end
                    else if (lastf)
                    begin
                        idx_reg <= '0;
                        cnt_reg <= '0;
                        if (q_reg.cmd == CMD_PIN)
                            state_reg <= S_EMPTY;
                        else
                        begin
                            state_reg  <= S_IDLE;
                            valid_next = 1'b1;
                            res_next   = '0;
                            res_next.status      = ST_MISSING;
                            res_next.last        = 1'b1;
                            res_next.read_total  = rd_reg;
                            res_next.write_total = wr_reg;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EMPTY:
                begin
                    if (m_empty)
                    begin
                        fvalid_reg[idx_reg] <= 1'b1;
                        fdirty_reg[idx_reg] <= 1'b0;
                        fpins_reg[idx_reg]  <= 8'd1;
                        fpage_reg[idx_reg]  <= q_reg.page_number;
                        fstamp_reg[idx_reg] <= stamp_reg + 32'd1;
                        stamp_reg <= stamp_reg + 32'd1;
                        rd_reg    <= rd_reg + 32'd1;
                        state_reg <= S_IDLE;
                        valid_next = 1'b1;
                        res_next   = '0;
                        res_next.frame       = 4'(idx_reg);
                        res_next.load        = 1'b1;
                        res_next.read_total  = rd_reg + 32'd1;
                        res_next.write_total = wr_reg;
                        res_next.pin_count   = 8'd1;
                        res_next.last        = 1'b1;
                    end
                    else if (lastf)
                    begin
                        // start the victim walk; FIFO begins at the pointer
                        idx_reg  <= (strat_reg || (CNT_BITS'(fptr_reg) >= n)) ? '0 : fptr_reg;
                        cnt_reg  <= '0;
                        have_reg <= 1'b0;
                        state_reg <= S_VICT;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_VICT:
                begin
                    logic                found;
                    logic [IDX_BITS-1:0] v;
                    found = 1'b0;
                    v     = idx_reg;
                    if (!strat_reg)
                        found = m_free;
                    else
                    begin
                        if (m_older)
                        begin
                            best_reg <= idx_reg;
                            have_reg <= 1'b1;
                        end
                        if (lastf)
                        begin
                            found = m_older || have_reg;
                            v     = m_older ? idx_reg : best_reg;
                        end
                    end
                    if (found)
                    begin
                        fdirty_reg[v] <= 1'b0;
                        fpins_reg[v]  <= 8'd1;
                        fpage_reg[v]  <= q_reg.page_number;
                        fstamp_reg[v] <= stamp_reg + 32'd1;
                        stamp_reg <= stamp_reg + 32'd1;
                        rd_reg    <= rd_reg + 32'd1;
                        fptr_reg  <= (v == nm1) ? '0 : v + 1'b1;
                        state_reg <= S_IDLE;
                        valid_next = 1'b1;
                        res_next   = '0;
                        res_next.frame       = 4'(v);
                        res_next.load        = 1'b1;
                        res_next.read_total  = rd_reg + 32'd1;
                        res_next.write_total = wr_reg;
                        res_next.pin_count   = 8'd1;
                        res_next.last        = 1'b1;
                        if (fdirty_reg[v])
                        begin
                            wr_reg <= wr_reg + 32'd1;
                            res_next.write_total  = wr_reg + 32'd1;
                            res_next.write_back   = 1'b1;
                            res_next.written_page = fpage_reg[v];
                        end
                    end
                    else if (lastf)
                    begin
                        state_reg  <= S_IDLE;
                        valid_next = 1'b1;
                        res_next   = '0;
                        res_next.status      = ST_PINNED;
                        res_next.last        = 1'b1;
                        res_next.read_total  = rd_reg;
                        res_next.write_total = wr_reg;
                    end
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    if (cur.valid && cur.dirty && m_free)
                    begin
                        wr_reg <= wr_reg + 32'd1;
                        fdirty_reg[idx_reg] <= 1'b0;
                        // release the held write result, hold this one
                        if (any_reg)
                        begin
                            valid_next = 1'b1;
                            res_next   = pend_reg;
                        end
                        any_reg  <= 1'b1;
                        pend_reg <= '{frame: 4'(idx_reg), hit: 1'b0, load: 1'b0,
                                      write_back: 1'b1, written_page: cur.page,
                                      status: ST_OK, read_total: rd_reg,
                                      write_total: wr_reg + 32'd1, pin_count: 8'd0,
                                      last: 1'b0};
                    end
                    if (lastf)
                        state_reg <= S_TAIL;
                    else
                    begin
                        idx_reg <= idx_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_TAIL:
                begin
                    // final flush result: the held write, or an empty result
                    state_reg  <= S_IDLE;
                    valid_next = 1'b1;
                    res_next   = '0;
                    res_next.read_total  = rd_reg;
                    res_next.write_total = wr_reg;
                    if (any_reg)
                        res_next = pend_reg;
                    res_next.last = 1'b1;
                end
                default:
                begin
                    state_reg  <= S_IDLE;
                    valid_next = 1'b1;
                    res_next   = '0;
                    res_next.last        = 1'b1;
                    res_next.read_total  = rd_reg;
                    res_next.write_total = wr_reg;
                end
            endcase
            valid_reg <= valid_next;
            res_reg   <= res_next;
        end
    end
`ifndef SYNTHESIS
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && res.last |-> !busy) else $error("last result while busy");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!busy) && !$past(start) |-> !valid) else $error("result without request");
    a_load_pin: assert property (@(posedge clk) disable iff (!rst_n)
        valid && res.load |-> res.pin_count == 8'd1) else $error("fill pin count");
`endif
endmodule
`default_nettype wire

// File: test/page_frame_table_fifo_lru_top_tb.sv
// Testbench for the page frame table with FIFO/LRU replacement: directed table, then
// random pin/unpin/dirty/force/flush traffic checked against an in-bench frame model.
// Depends on pft_pkg and page_frame_table_fifo_lru_top.
`timescale 1ns / 100ps
`default_nettype none
module page_frame_table_fifo_lru_top_tb;
    import pft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       valid;
    res_t       res;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [4:0] cfg_data;

    page_frame_table_fifo_lru_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .valid     (valid),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Frame table model
    logic [PAGE_BITS-1:0] m_page [FRAMES];
    logic                 m_valid [FRAMES];
    logic                 m_dirty [FRAMES];
    logic [7:0]           m_pins [FRAMES];
    logic [31:0]          m_stamp [FRAMES];
    logic [31:0]          m_stamp_ctr;
    logic [31:0]          m_reads;
    logic [31:0]          m_writes;
    logic [4:0]           m_fifo_ptr;
    logic                 m_lru;
    logic [4:0]           m_frames_cfg;

    res_t expected_results[$];
    int   error_count;
    int   idle_cycles;
    bit   timed_out;
    bit   pool_warm;

    typedef struct {
        logic [2:0]           cmd;
        logic [PAGE_BITS-1:0] page;
        bit                   typed;
        res_t                 want;
    } stim_row_t;

    stim_row_t directed_rows[$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic int active_count();
        if (m_frames_cfg == 0) return 1;
        if (m_frames_cfg > FRAMES) return FRAMES;
        return m_frames_cfg;
    endfunction

    function automatic res_t make_result(input int fr, input logic h, input logic ld,
                                         input logic wb, input logic [PAGE_BITS-1:0] wp,
                                         input logic [1:0] st, input logic [7:0] pc);
        res_t r;
        r.frame        = fr[3:0];
        r.hit          = h;
        r.load         = ld;
        r.write_back   = wb;
        r.written_page = wp;
        r.status       = st;
        r.read_total   = m_reads;
        r.write_total  = m_writes;
        r.pin_count    = pc;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void fill_frame(input int i, input logic [PAGE_BITS-1:0] pg);
        m_page[i]  = pg;
        m_valid[i] = 1'b1;
        m_dirty[i] = 1'b0;
        m_pins[i]  = 8'd1;
        m_reads++;
        m_stamp_ctr++;
        m_stamp[i] = m_stamp_ctr;
    endfunction

    function automatic int lookup_page(input int n, input logic [PAGE_BITS-1:0] pg);
        for (int i = 0; i < n; i++)
            if (m_valid[i] && m_page[i] == pg) return i;
        return -1;
    endfunction

    function automatic int choose_victim(input int n);
        int p;
        int best;
        best = -1;
        if (!m_lru)
        begin
            p = (m_fifo_ptr < n) ? int'(m_fifo_ptr) : 0;
            for (int i = 0; i < n; i++)
            begin
                if (m_pins[p] == 0) return p;
                p = (p + 1 >= n) ? 0 : p + 1;
            end
            return -1;
        end
        for (int i = 0; i < n; i++)
            if (m_pins[i] == 0 && (best < 0 || m_stamp[i] < m_stamp[best])) best = i;
        return best;
    endfunction

    // Apply one request to the model and queue its results
    function automatic void predict_request(input logic [2:0] cmd,
                                            input logic [PAGE_BITS-1:0] pg);
        int   n;
        int   f;
        int   k;
        logic wb;
        logic [PAGE_BITS-1:0] wp;
        res_t r;
        n = active_count();
        k = expected_results.size();
        if (cmd == CMD_PIN)
        begin
            f = lookup_page(n, pg);
            if (f >= 0)
            begin
                if (m_pins[f] != 8'hff) m_pins[f]++;
                m_stamp_ctr++;
                if (m_lru) m_stamp[f] = m_stamp_ctr;
                expected_results.push_back(make_result(f, 1, 0, 0, 0, ST_OK, m_pins[f]));
            end
            else
            begin
                f = -1;
                for (int i = 0; i < n; i++)
                    if (!m_valid[i] && f < 0) f = i;
                if (f >= 0)
                begin
                    fill_frame(f, pg);
                    expected_results.push_back(make_result(f, 0, 1, 0, 0, ST_OK, 1));
                end
                else
                begin
                    f = choose_victim(n);
                    if (f < 0)
                        expected_results.push_back(make_result(0, 0, 0, 0, 0, ST_PINNED, 0));
                    else
                    begin
                        wb = m_dirty[f];
                        wp = wb ? m_page[f] : '0;
                        if (wb) m_writes++;
                        fill_frame(f, pg);
                        m_fifo_ptr = (f + 1 < n) ? 5'(f + 1) : 5'd0;
                        expected_results.push_back(make_result(f, 0, 1, wb, wp, ST_OK, 1));
                    end
                end
            end
        end
        else if (cmd == CMD_UNPIN || cmd == CMD_DIRTY || cmd == CMD_FORCE)
        begin
            f = lookup_page(n, pg);
            if (f < 0)
                expected_results.push_back(make_result(0, 0, 0, 0, 0, ST_MISSING, 0));
            else if (cmd == CMD_UNPIN)
            begin
                if (m_pins[f] != 0) m_pins[f]--;
                expected_results.push_back(make_result(f, 1, 0, 0, 0, ST_OK, m_pins[f]));
            end
            else if (cmd == CMD_DIRTY)
            begin
                m_dirty[f] = 1'b1;
                expected_results.push_back(make_result(f, 1, 0, 0, 0, ST_OK, m_pins[f]));
            end
            else
            begin
                m_writes++;
                m_dirty[f] = 1'b0;
                expected_results.push_back(make_result(f, 1, 0, 1, m_page[f], ST_OK,
                                                       m_pins[f]));
            end
        end
        else if (cmd == CMD_FLUSH)
        begin
            for (int i = 0; i < n; i++)
                if (m_valid[i] && m_dirty[i] && m_pins[i] == 0)
                begin
                    m_writes++;
                    m_dirty[i] = 1'b0;
                    expected_results.push_back(make_result(i, 0, 0, 1, m_page[i], ST_OK, 0));
                end
            if (expected_results.size() == k)
                expected_results.push_back(make_result(0, 0, 0, 0, 0, ST_OK, 0));
        end
        else
            expected_results.push_back(make_result(0, 0, 0, 0, 0, ST_OK, 0));
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
    endfunction

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", res[63:0], 64'd0);
            else
            begin
                w = expected_results.pop_front();
                if (res.frame !== w.frame) report_mismatch("frame", res.frame, w.frame);
                if (res.hit !== w.hit) report_mismatch("hit", res.hit, w.hit);
                if (res.load !== w.load) report_mismatch("load", res.load, w.load);
                if (res.write_back !== w.write_back)
                    report_mismatch("write_back", res.write_back, w.write_back);
                if (res.written_page !== w.written_page)
                    report_mismatch("written_page", res.written_page, w.written_page);
                if (res.status !== w.status) report_mismatch("status", res.status, w.status);
                if (res.read_total !== w.read_total)
                    report_mismatch("read_total", res.read_total, w.read_total);
                if (res.write_total !== w.write_total)
                    report_mismatch("write_total", res.write_total, w.write_total);
                if (res.pin_count !== w.pin_count)
                    report_mismatch("pin_count", res.pin_count, w.pin_count);
                if (res.last !== w.last) report_mismatch("last", res.last, w.last);
            end
        end
    end

    // Watchdog: cycles out of reset with no request accepted, no result and no register write
    always @(posedge clk)
    begin
        if ((start && !busy) || valid || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_register(input logic [0:0] idx, input logic [4:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_STRATEGY) m_lru = value[0];
        else m_frames_cfg = value;
    endtask

    task automatic drain();
        while (expected_results.size() != 0 || busy) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Issue one request and predict it; a typed row checks the prediction against its entry
    task automatic send_request(input logic [2:0] cmd, input logic [PAGE_BITS-1:0] pg,
                                input bit typed, input res_t want);
        int   k;
        res_t got;
        start <= 1'b1;
        req   <= '{cmd: cmd, page_number: pg};
        @(posedge clk);
        while (busy) @(posedge clk);
        k = expected_results.size();
        predict_request(cmd, pg);
        if (typed)
        begin
            got = expected_results[k];
            if (got !== want) report_mismatch("directed prediction", got[63:0], want[63:0]);
        end
    endtask

    function automatic res_t typed_res(input int fr, input logic h, input logic ld,
                                       input logic wb, input logic [PAGE_BITS-1:0] wp,
                                       input logic [1:0] st, input int rd, input int wr,
                                       input logic [7:0] pc);
        res_t r;
        r = '{frame: fr[3:0], hit: h, load: ld, write_back: wb, written_page: wp,
              status: st, read_total: rd, write_total: wr, pin_count: pc, last: 1'b1};
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] cmd, input logic [PAGE_BITS-1:0] pg,
                                    input bit typed, input res_t want);
        stim_row_t s;
        s.cmd = cmd;
        s.page = pg;
        s.typed = typed;
        s.want = want;
        directed_rows.push_back(s);
    endfunction

    function automatic logic [PAGE_BITS-1:0] pick_page();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 8) return PAGE_BITS'($urandom_range(0, 23));
        if (sel == 8) return PAGE_BITS'($urandom);
        return {PAGE_BITS{1'b1}} - PAGE_BITS'($urandom_range(0, 3));
    endfunction

    task automatic random_phase(input int count);
        int   burst;
        logic [2:0] cmd;
        int   sel;
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst = $urandom_range(1, 12);
            end
            burst--;
            sel = $urandom_range(0, 99);
            if (sel < 40) cmd = CMD_PIN;
            else if (sel < 65) cmd = CMD_UNPIN;
            else if (sel < 78) cmd = CMD_DIRTY;
            else if (sel < 86) cmd = CMD_FORCE;
            else if (sel < 96) cmd = CMD_FLUSH;
            else cmd = 3'($urandom_range(5, 7));
            send_request(cmd, pick_page(), 1'b0, '0);
        end
        start <= 1'b0;
    endtask

    initial
    begin
        res_t none;
        none        = '0;
        error_count = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            m_valid[i] = 1'b0;
            m_dirty[i] = 1'b0;
            m_pins[i]  = '0;
            m_page[i]  = '0;
            m_stamp[i] = '0;
        end
        m_stamp_ctr  = '0;
        m_reads      = '0;
        m_writes     = '0;
        m_fifo_ptr   = '0;
        m_lru        = 1'b0;
        m_frames_cfg = 5'd16;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on two frames: extremes, every command, each special case
        write_register(REG_FRAMES, 5'd2);
        add_row(CMD_FLUSH, '0, 1, typed_res(0, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        add_row(CMD_UNPIN, '1, 1, typed_res(0, 0, 0, 0, 0, ST_MISSING, 0, 0, 0));
        add_row(CMD_PIN, '0, 1, typed_res(0, 0, 1, 0, 0, ST_OK, 1, 0, 1));
        add_row(CMD_PIN, '1, 1, typed_res(1, 0, 1, 0, 0, ST_OK, 2, 0, 1));
        add_row(CMD_PIN, 24'h5a5a5a, 1, typed_res(0, 0, 0, 0, 0, ST_PINNED, 2, 0, 0));
        add_row(CMD_DIRTY, '1, 1, typed_res(1, 1, 0, 0, 0, ST_OK, 2, 0, 1));
        add_row(CMD_FORCE, '1, 1, typed_res(1, 1, 0, 1, '1, ST_OK, 2, 1, 1));
        add_row(CMD_DIRTY, '1, 0, none);
        add_row(CMD_UNPIN, '1, 0, none);
        add_row(CMD_UNPIN, '1, 1, typed_res(1, 1, 0, 0, 0, ST_OK, 2, 1, 0));
        add_row(CMD_DIRTY, '0, 0, none);
        add_row(CMD_UNPIN, '0, 0, none);
        add_row(CMD_FLUSH, '0, 0, none);
        add_row(CMD_PIN, 24'ha5a5a5, 0, none);
        add_row(CMD_PIN, 24'ha5a5a5, 0, none);
        add_row(3'd5, '1, 0, none);
        add_row(3'd7, '0, 0, none);
        foreach (directed_rows[i])
            send_request(directed_rows[i].cmd, directed_rows[i].page,
                         directed_rows[i].typed, directed_rows[i].want);
        start <= 1'b0;
        drain();

        // Saturate a pin count at its ceiling
        for (int i = 0; i < 256; i++)
            send_request(CMD_PIN, 24'ha5a5a5, 1'b0, none);
        start <= 1'b0;
        drain();

        write_register(REG_FRAMES, 5'd4);
        random_phase(30);
        drain();
        write_register(REG_STRATEGY, 5'd1);
        write_register(REG_FRAMES, 5'd16);
        random_phase(30);
        drain();
        write_register(REG_FRAMES, 5'd0);
        random_phase(20);
        drain();
        write_register(REG_FRAMES, 5'd31);
        write_register(REG_STRATEGY, 5'd0);
        random_phase(27);
        drain();
        write_register(REG_FRAMES, 5'd3);
        write_register(REG_STRATEGY, 5'd1);
        random_phase(30);
        drain();

        if (error_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
